/* design/grid_ray_horizontal_hit_assert.svh */
// Assertion macros used by the checker file.
`ifndef GRID_RAY_HORIZONTAL_HIT_ASSERT_SVH
`define GRID_RAY_HORIZONTAL_HIT_ASSERT_SVH

// Implication checked in the same cycle, ignored while reset is high.
`define GRH_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the following cycle, active during reset as well.
`define GRH_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* design/grh_pkg.sv */
package grh_pkg;

   localparam int BLOCK_PIXELS   = 64;
   localparam int MAP_SIDE       = 64;
   localparam int COT_TABLE_BITS = 12;

   localparam int SIDE_W   = $clog2(MAP_SIDE);
   localparam int ADDR_W   = 2 * SIDE_W;
   localparam int BP_SH    = $clog2(BLOCK_PIXELS);
   localparam int BLK_SH   = BP_SH + 8;
   localparam int CNT_W    = (ADDR_W > 6) ? ADDR_W : 6;
   localparam int CORDIC_STAGES = 18;
   localparam int DIV_BITS = 23;
   localparam int DY_W     = BLK_SH + 2;
   localparam int PROD_W   = DY_W + 24;

   localparam logic signed [23:0] SAT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SAT_MIN = 24'sh800000;

   localparam logic [1:0] REG_PLAYER_X   = 2'd0;
   localparam logic [1:0] REG_PLAYER_Y   = 2'd1;
   localparam logic [1:0] REG_MAP_WIDTH  = 2'd2;
   localparam logic [1:0] REG_MAP_HEIGHT = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   typedef struct packed {
      logic [19:0] player_x;
      logic [19:0] player_y;
      logic [6:0]  map_width;
      logic [6:0]  map_height;
   } cfg_type;

   typedef struct packed {
      logic              clear_wr;
      logic [ADDR_W-1:0] clear_addr;
      logic              map_wr;
      logic              cast_load;
      logic              cordic_step;
      logic [4:0]        stage;
      logic              div_init;
      logic              div_step;
      logic              div_fin;
      logic              geom_a;
      logic              geom_b;
      logic              walk_rd;
      logic              walk_step;
      logic              out_walk;
      logic              out_horiz;
   } cmd_type;

   typedef struct packed {
      logic horiz;
      logic walk_stop;
   } status_type;

   function automatic logic [15:0] atan_step(input logic [4:0] i);
      case (i)
         5'd0:    atan_step = 16'd32768;
         5'd1:    atan_step = 16'd19344;
         5'd2:    atan_step = 16'd10221;
         5'd3:    atan_step = 16'd5188;
         5'd4:    atan_step = 16'd2604;
         5'd5:    atan_step = 16'd1303;
         5'd6:    atan_step = 16'd652;
         5'd7:    atan_step = 16'd326;
         5'd8:    atan_step = 16'd163;
         5'd9:    atan_step = 16'd81;
         5'd10:   atan_step = 16'd41;
         5'd11:   atan_step = 16'd20;
         5'd12:   atan_step = 16'd10;
         5'd13:   atan_step = 16'd5;
         5'd14:   atan_step = 16'd3;
         5'd15:   atan_step = 16'd1;
         5'd16:   atan_step = 16'd1;
         default: atan_step = 16'd0;
      endcase
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      if (v > 48'(SAT_MAX)) begin
         sat24 = SAT_MAX;
      end else if (v < 48'(SAT_MIN)) begin
         sat24 = SAT_MIN;
      end else begin
         sat24 = v[23:0];
      end
   endfunction

endpackage

/* design/grh_csr.sv */
module grh_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output grh_pkg::cfg_type cfg
);
   import grh_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr;
   logic [1:0] idx;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_PLAYER_X:   cfg_in.player_x   = csr_pwdata[19:0];
            REG_PLAYER_Y:   cfg_in.player_y   = csr_pwdata[19:0];
            REG_MAP_WIDTH:  cfg_in.map_width  = csr_pwdata[6:0];
            REG_MAP_HEIGHT: cfg_in.map_height = csr_pwdata[6:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_PLAYER_X:   csr_prdata = {12'd0, cfg_ff.player_x};
         REG_PLAYER_Y:   csr_prdata = {12'd0, cfg_ff.player_y};
         REG_MAP_WIDTH:  csr_prdata = {25'd0, cfg_ff.map_width};
         REG_MAP_HEIGHT: csr_prdata = {25'd0, cfg_ff.map_height};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{player_x: 20'd0, player_y: 20'd0, map_width: 7'd64, map_height: 7'd64};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

/* design/grh_ctrl.sv */
module grh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_op,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  grh_pkg::status_type status,
   output grh_pkg::cmd_type    cmd
);
   import grh_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CORDIC, S_DIV_INIT, S_DIV, S_DIV_FIN,
      S_GEOM_A, S_GEOM_B, S_WALK_RD, S_WALK_EVAL, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.clear_addr = cnt_ff[ADDR_W-1:0];
      cmd.stage      = cnt_ff[4:0];
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[ADDR_W-1:0] == {ADDR_W{1'b1}}) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  cmd.map_wr = 1'b1;
               end else if (status.horiz) begin
                  cmd.out_horiz = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.cast_load = 1'b1;
                  cnt_in   = '0;
                  state_in = S_CORDIC;
               end
            end
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STAGES - 1)) begin
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_BITS - 1)) begin
               state_in = S_DIV_FIN;
            end
         end
         S_DIV_FIN: begin
            cmd.div_fin = 1'b1;
            state_in = S_GEOM_A;
         end
         S_GEOM_A: begin
            cmd.geom_a = 1'b1;
            state_in = S_GEOM_B;
         end
         S_GEOM_B: begin
            cmd.geom_b = 1'b1;
            cnt_in   = '0;
            state_in = S_WALK_RD;
         end
         S_WALK_RD: begin
            cmd.walk_rd = 1'b1;
            state_in = S_WALK_EVAL;
         end
         S_WALK_EVAL: begin
            // Stop at a wall, outside the map, or on the last allowed point.
            if (status.walk_stop || cnt_ff == CNT_W'(MAP_SIDE + 1)) begin
               cmd.out_walk = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.walk_step = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end
         S_DONE: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

/* design/grh_datapath.sv */
module grh_datapath (
   input  logic                clock,
   input  grh_pkg::cfg_type    cfg,
   input  logic [31:0]         req_tdata,
   input  grh_pkg::cmd_type    cmd,
   output grh_pkg::status_type status,
   output logic [47:0]         rsp_tdata,
   output logic [2:0]          rsp_tuser
);
   import grh_pkg::*;

   localparam int HALF = 1 << (COT_TABLE_BITS - 1);

   logic [5:0]  cell_column;
   logic [5:0]  cell_row;
   logic        cell_is_wall;
   logic [15:0] ray_angle;
   logic [COT_TABLE_BITS-1:0] q;
   logic [15:0] ang;

   logic                     mem [2**ADDR_W];
   logic                     wall_ff;
   logic signed [19:0]       z_ff;
   logic signed [33:0]       x_ff, y_ff;
   logic                     up_ff, neg_ff, yzero_ff, sat_ff, oob_ff;
   logic [40:0]              rem_ff;
   logic [54:0]              dsh_ff;
   logic [DIV_BITS-1:0]      quo_ff;
   logic signed [23:0]       cot_ff, ax_ff, ay_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [24:0]       dx_ff;
   logic signed [23:0]       hx_ff, hy_ff;
   logic                     face_ff, nohit_ff, left_ff;

   logic signed [33:0]  sx, sy;
   logic signed [19:0]  at;
   logic [33:0]         absx, absy;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [6:0]          wclip, hclip;
   logic [31:0]         wlim, hlim;
   logic [BLK_SH-1:0]   off;
   logic signed [DY_W-1:0] diffy;
   logic signed [23:0]  ay0, dxm;
   logic signed [31:0]  cot_sc;
   logic signed [PROD_W-1:0] prod_sh;
   logic                oob;

   assign cell_column  = req_tdata[5:0];
   assign cell_row     = req_tdata[11:6];
   assign cell_is_wall = req_tdata[12];
   assign ray_angle    = req_tdata[28:13];
   assign q   = ray_angle[15 -: COT_TABLE_BITS];
   assign ang = {q, {(16 - COT_TABLE_BITS){1'b0}}};
   assign status.horiz = (q == '0) || (q == COT_TABLE_BITS'(HALF));
   assign status.walk_stop = oob_ff || wall_ff;

   // Map writes: clearing pass after reset, or cell writes from the input.
   assign wr_addr = cmd.clear_wr ? cmd.clear_addr
                  : {cell_row[SIDE_W-1:0], cell_column[SIDE_W-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[wr_addr] <= 1'b0;
      end else if (cmd.map_wr && (32'(cell_column) < 32'(MAP_SIDE))
                   && (32'(cell_row) < 32'(MAP_SIDE))) begin
         mem[wr_addr] <= cell_is_wall;
      end
   end

   assign rd_addr = {ay_ff[BLK_SH +: SIDE_W], ax_ff[BLK_SH +: SIDE_W]};

   always_ff @(posedge clock) begin
      if (cmd.walk_rd) begin
         wall_ff <= mem[rd_addr];
      end
   end

   assign sx = x_ff >>> cmd.stage;
   assign sy = y_ff >>> cmd.stage;
   assign at = signed'({4'd0, atan_step(cmd.stage)});
   assign absx = x_ff[33] ? 34'(-x_ff) : x_ff;
   assign absy = y_ff[33] ? 34'(-y_ff) : y_ff;

   assign wclip = (32'(cfg.map_width)  > 32'(MAP_SIDE)) ? 7'(MAP_SIDE) : cfg.map_width;
   assign hclip = (32'(cfg.map_height) > 32'(MAP_SIDE)) ? 7'(MAP_SIDE) : cfg.map_height;
   assign wlim  = 32'(wclip) << BLK_SH;
   assign hlim  = 32'(hclip) << BLK_SH;
   assign oob = ax_ff[23] || ay_ff[23] || (32'(ax_ff[22:0]) >= wlim)
             || (32'(ay_ff[22:0]) >= hlim);

   assign off   = cfg.player_y[BLK_SH-1:0];
   assign diffy = up_ff ? (DY_W'(off) + DY_W'(256)) : (DY_W'(off) - DY_W'(1 << BLK_SH));
   assign ay0   = up_ff ? (24'({cfg.player_y[19:BLK_SH], off & '0}) - 24'sd256)
                        : (24'({cfg.player_y[19:BLK_SH], off & '0}) + 24'(1 << BLK_SH));
   assign cot_sc = 32'(cot_ff) <<< BP_SH;
   assign dxm    = sat24(48'(cot_sc));
   assign prod_sh = prod_ff >>> 8;

   always_ff @(posedge clock) begin
      if (cmd.cast_load) begin
         z_ff  <= 20'(signed'(ang[14:0])) <<< 2;
         x_ff  <= 34'sd1 <<< 30;
         y_ff  <= '0;
         up_ff <= ~ang[15];
      end
      if (cmd.cordic_step) begin
         if (!z_ff[19]) begin
            x_ff <= x_ff - sy;
            y_ff <= y_ff + sx;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + sy;
            y_ff <= y_ff - sx;
            z_ff <= z_ff + at;
         end
      end
      if (cmd.div_init) begin
         neg_ff   <= x_ff[33] ^ y_ff[33];
         yzero_ff <= (y_ff == '0);
         sat_ff   <= ({22'd0, absx, 8'd0} >= {absy, 23'd0});
         rem_ff   <= {absx[32:0], 8'd0};
         dsh_ff   <= {absy[32:0], 22'd0};
         quo_ff   <= '0;
      end
      if (cmd.div_step) begin
         if (55'(rem_ff) >= dsh_ff) begin
            rem_ff <= 41'(55'(rem_ff) - dsh_ff);
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.div_fin) begin
         if (yzero_ff) begin
            cot_ff <= SAT_MAX;
         end else if (sat_ff) begin
            cot_ff <= neg_ff ? -SAT_MAX : SAT_MAX;
         end else begin
            cot_ff <= neg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});
         end
      end
      if (cmd.geom_a) begin
         prod_ff <= PROD_W'(diffy) * PROD_W'(cot_ff);
         ay_ff   <= ay0;
         dx_ff   <= up_ff ? 25'(dxm) : -25'(dxm);
      end
      if (cmd.geom_b) begin
         ax_ff <= sat24(48'(signed'({28'd0, cfg.player_x})) + 48'(prod_sh));
      end
      if (cmd.walk_rd) begin
         oob_ff <= oob;
      end
      if (cmd.walk_step) begin
         ax_ff <= sat24(48'(ax_ff) + 48'(dx_ff));
         ay_ff <= sat24(48'(ay_ff) + (up_ff ? -48'sd1 <<< BLK_SH : 48'sd1 <<< BLK_SH));
      end
      if (cmd.out_walk) begin
         hx_ff    <= ax_ff;
         hy_ff    <= ay_ff;
         face_ff  <= ~up_ff;
         nohit_ff <= 1'b0;
         left_ff  <= oob_ff || !wall_ff;
      end
      if (cmd.out_horiz) begin
         hx_ff    <= SAT_MAX;
         hy_ff    <= SAT_MAX;
         face_ff  <= 1'b0;
         nohit_ff <= 1'b1;
         left_ff  <= 1'b0;
      end
   end

   assign rsp_tdata = {hy_ff, hx_ff};
   assign rsp_tuser = {left_ff, nohit_ff, face_ff};
endmodule

/* design/grid_ray_horizontal_hit.sv */
// Horizontal grid-line hit finder for one ray on a 64 x 64 one-bit wall map.
// Write beats (tuser 0) set one map cell. A cast beat (tuser 1) runs a
// CORDIC for the cotangent, a divide and sign fix, the setup states
// S_GEOM_A and S_GEOM_B with the one multiply, then a map memory read and
// a stop check per walk point, up to 66 points. Horizontal rays answer
// in the next cycle. After reset the block clears the map one cell a
// cycle and takes no beat until the pass is done; register writes are
// taken during the pass.
module grid_ray_horizontal_hit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_column[5:0], cell_row[11:6], cell_is_wall[12], ray_angle[28:13]
   input  logic [31:0] req_tdata,
   // operation[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // hit_x[23:0], hit_y[47:24]
   output logic [47:0] rsp_tdata,
   // wall_face[0], no_hit[1], left_map[2]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import grh_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   grh_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   grh_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_op(req_tuser), .req_tready,
      .rsp_tvalid, .rsp_tready, .status, .cmd
   );

   grh_datapath u_dp (
      .clock, .cfg, .req_tdata, .cmd, .status, .rsp_tdata, .rsp_tuser
   );
endmodule

/* design/grh_checker.sv */
`include "grid_ray_horizontal_hit_assert.svh"

module grh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   // One ray at a time: no new beat is taken while a result is pending.
   `GRH_ASSERT_IMP(a_busy_excl, 1'b1, !(req_tready && rsp_tvalid), "ready while result pending")
   // A stalled result holds its payload.
   `GRH_ASSERT_NXT(a_rsp_hold, !reset && rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   // The map clearing pass follows every reset.
   `GRH_ASSERT_NXT(a_clear_after_reset, reset, !req_tready && !rsp_tvalid, "beat taken during clear")
   // A horizontal result always carries saturated coordinates.
   `GRH_ASSERT_IMP(a_nohit_coords, rsp_tvalid && rsp_tuser[1], rsp_tdata == 48'h7FFFFF7FFFFF && !rsp_tuser[2], "bad horizontal result")
endmodule

bind grid_ray_horizontal_hit grh_checker u_grh_checker (.*);
